[rtl/rbs_pkg.sv]
// Package: shared constants for the ray/box slab intersection unit.
`default_nettype none
package rbs_pkg;
  localparam int COORD_WIDTH   = 32;
  localparam int FRAC_BITS     = 16;
  localparam int EPS_WIDTH     = 31;
  localparam int REG_IDX_WIDTH = 3;
  localparam int NUM_AXES      = 3;

  localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MAX_Z = 3'd5;
  localparam logic [REG_IDX_WIDTH-1:0] REG_HIT_EPS   = 3'd6;

  localparam longint BOX_MIN_RESET = 0;
  localparam longint BOX_MAX_RESET = 65536;
  localparam logic [EPS_WIDTH-1:0] HIT_EPS_RESET = 31'd7;
endpackage
`default_nettype wire

[rtl/rbs_ifs.sv]
// Interfaces: ray input, hit output and configuration write channels.
`default_nettype none
interface rbs_ray_if #(parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rbs_hit_if;
  logic valid;
  logic ready;
  logic is_hit;
  modport source (output valid, is_hit, input ready);
  modport sink (input valid, is_hit, output ready);
endinterface

interface rbs_cfg_if #(parameter int DATA_WIDTH = rbs_pkg::COORD_WIDTH);
  logic                                   valid;
  logic                                   ready;
  logic [rbs_pkg::REG_IDX_WIDTH-1:0]      index;
  logic [DATA_WIDTH-1:0]                  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/rbs_div.sv]
// Pipelined restoring divider: (mag << 16) / den, one quotient bit per stage.
`default_nettype none
module rbs_div #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH,
  parameter int SB_WIDTH    = 1
) (
  input  wire logic                                    clk,
  input  wire logic                                    en,
  input  wire logic [COORD_WIDTH-1:0]                  mag,
  input  wire logic [COORD_WIDTH-1:0]                  den,
  input  wire logic [SB_WIDTH-1:0]                     sb_in,
  output logic [COORD_WIDTH+rbs_pkg::FRAC_BITS-1:0]    quo,
  output logic [SB_WIDTH-1:0]                          sb_out
);
  localparam int QW = COORD_WIDTH + rbs_pkg::FRAC_BITS;

  logic [COORD_WIDTH-1:0] rem_r [QW];
  logic [QW-1:0]          num_r [QW];
  logic [QW-1:0]          quo_r [QW];
  logic [COORD_WIDTH-1:0] den_r [QW];
  logic [SB_WIDTH-1:0]    sb_r  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [COORD_WIDTH-1:0] rem_i;
    logic [QW-1:0]          num_i;
    logic [QW-1:0]          quo_i;
    logic [COORD_WIDTH-1:0] den_i;
    logic [SB_WIDTH-1:0]    sb_i;
    logic [COORD_WIDTH:0]   trial;
    logic [COORD_WIDTH:0]   diff;
    logic                   ge;

    if (s == 0) begin : g_first
      assign rem_i = '0;
      assign num_i = {mag, {rbs_pkg::FRAC_BITS{1'b0}}};
      assign quo_i = '0;
      assign den_i = den;
      assign sb_i  = sb_in;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign num_i = num_r[s-1];
      assign quo_i = quo_r[s-1];
      assign den_i = den_r[s-1];
      assign sb_i  = sb_r[s-1];
    end

    assign trial = {rem_i, num_i[QW-1]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
        num_r[s] <= {num_i[QW-2:0], 1'b0};
        quo_r[s] <= {quo_i[QW-2:0], ge};
        den_r[s] <= den_i;
        sb_r[s]  <= sb_i;
      end
    end
  end

  assign quo    = quo_r[QW-1];
  assign sb_out = sb_r[QW-1];
endmodule
`default_nettype wire

[rtl/rbs_slab_lane.sv]
// One axis lane: slab setup, entry and exit divides, saturation.
`default_nettype none
module rbs_slab_lane #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [COORD_WIDTH-1:0] org,
  input  wire logic signed [COORD_WIDTH-1:0] dir,
  input  wire logic signed [COORD_WIDTH-1:0] lo,
  input  wire logic signed [COORD_WIDTH-1:0] hi,
  output logic signed [COORD_WIDTH-1:0]      tn,
  output logic signed [COORD_WIDTH-1:0]      tx,
  output logic                               miss
);
  localparam int CW = COORD_WIDTH;
  localparam int QW = CW + rbs_pkg::FRAC_BITS;
  localparam logic [QW-1:0] POSLIM_Q = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [QW-1:0] NEGLIM_Q = POSLIM_Q + QW'(1);
  localparam logic [CW-1:0] POSMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] NEGMIN = {1'b1, {(CW-1){1'b0}}};

  // setup
  logic dneg, dzero, inslab;
  logic signed [CW-1:0] pn, px;
  logic signed [CW:0] dn, dx;
  logic [CW-1:0] dmag;

  assign dneg   = dir[CW-1];
  assign dzero  = (dir == '0);
  assign inslab = (org >= lo) && (org <= hi);
  assign pn     = dneg ? hi : lo;
  assign px     = dneg ? lo : hi;
  assign dn     = {pn[CW-1], pn} - {org[CW-1], org};
  assign dx     = {px[CW-1], px} - {org[CW-1], org};
  assign dmag   = dneg ? CW'(-dir) : dir;

  logic [CW-1:0] mag_n, mag_x, den;
  logic neg_n, neg_x, dzero_r, inslab_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_n    <= dn[CW] ? CW'(-dn) : dn[CW-1:0];
      mag_x    <= dx[CW] ? CW'(-dx) : dx[CW-1:0];
      neg_n    <= dn[CW] ^ dneg;
      neg_x    <= dx[CW] ^ dneg;
      den      <= dmag;
      dzero_r  <= dzero;
      inslab_r <= inslab;
    end
  end

  logic [QW-1:0] qn, qx;
  logic [2:0] sb_n;
  logic [0:0] sb_x;

  rbs_div #(.COORD_WIDTH(CW), .SB_WIDTH(3)) u_div_entry (
    .clk(clk), .en(en), .mag(mag_n), .den(den),
    .sb_in({dzero_r, inslab_r, neg_n}), .quo(qn), .sb_out(sb_n)
  );

  rbs_div #(.COORD_WIDTH(CW), .SB_WIDTH(1)) u_div_exit (
    .clk(clk), .en(en), .mag(mag_x), .den(den),
    .sb_in(neg_x), .quo(qx), .sb_out(sb_x)
  );

  logic [CW-1:0] sat_n, sat_x;

  always_comb begin
    if (sb_n[0]) begin
      sat_n = (qn > NEGLIM_Q) ? NEGMIN : CW'(-qn);
    end else begin
      sat_n = (qn > POSLIM_Q) ? POSMAX : qn[CW-1:0];
    end
    if (sb_x[0]) begin
      sat_x = (qx > NEGLIM_Q) ? NEGMIN : CW'(-qx);
    end else begin
      sat_x = (qx > POSLIM_Q) ? POSMAX : qx[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tn   <= sb_n[2] ? NEGMIN : sat_n;
      tx   <= sb_n[2] ? POSMAX : sat_x;
      miss <= sb_n[2] & ~sb_n[1];
    end
  end
endmodule
`default_nettype wire

[rtl/rbs_merge.sv]
// Merge stage: largest entry, smallest exit, hit decision.
`default_nettype none
module rbs_merge #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [COORD_WIDTH-1:0]       tn [rbs_pkg::NUM_AXES],
  input  wire logic signed [COORD_WIDTH-1:0]       tx [rbs_pkg::NUM_AXES],
  input  wire logic [rbs_pkg::NUM_AXES-1:0]        miss,
  input  wire logic [rbs_pkg::EPS_WIDTH-1:0]       eps,
  output logic                                     is_hit
);
  localparam int CW   = COORD_WIDTH;
  localparam int CMPW = ((CW > rbs_pkg::EPS_WIDTH) ? CW : rbs_pkg::EPS_WIDTH) + 1;

  logic signed [CW-1:0] m01, n01, t0_next, t1_next, t0, t1;
  logic any_miss;

  assign m01     = (tn[0] > tn[1]) ? tn[0] : tn[1];
  assign t0_next = (tn[2] > m01) ? tn[2] : m01;
  assign n01     = (tx[0] < tx[1]) ? tx[0] : tx[1];
  assign t1_next = (tx[2] < n01) ? tx[2] : n01;

  always_ff @(posedge clk) begin
    if (en) begin
      t0       <= t0_next;
      t1       <= t1_next;
      any_miss <= |miss;
    end
  end

  logic signed [CMPW-1:0] t1_ext, eps_ext;
  assign t1_ext  = CMPW'(t1);
  assign eps_ext = {{(CMPW-rbs_pkg::EPS_WIDTH){1'b0}}, eps};

  always_ff @(posedge clk) begin
    if (en) begin
      is_hit <= ~any_miss && (t0 < t1) && (t1_ext > eps_ext);
    end
  end
endmodule
`default_nettype wire

[rtl/ray_box_slab_intersection_unit.sv]
// Top level: ray versus axis-aligned box slab test, one ray per cycle.
//
//  channel  dir  payload                                     
//  ray_in   in   origin_x/y/z, dir_x/y/z (signed Q16.16)
//  hit_out  out  is_hit
//  cfg      in   index, data (box corners, hit_epsilon)
//
// The pipeline has one setup stage, one divider stage per quotient bit
// (COORD_WIDTH+16), one saturation stage and two merge stages. Throughput is
// one ray per cycle. Three axis lanes each run two pipelined dividers. A stall
// on hit_out freezes the whole pipeline; rst clears the valid chain, the box
// registers and hit_epsilon. cfg is always ready.
`default_nettype none
module ray_box_slab_intersection_unit #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH
) (
  input wire logic clk,
  input wire logic rst,
  rbs_ray_if.sink  ray_in,
  rbs_hit_if.source hit_out,
  rbs_cfg_if.sink  cfg
);
  localparam int CW  = COORD_WIDTH;
  localparam int NA  = rbs_pkg::NUM_AXES;
  localparam int LAT = CW + rbs_pkg::FRAC_BITS + 4;

  logic signed [CW-1:0] box_min [NA];
  logic signed [CW-1:0] box_max [NA];
  logic [rbs_pkg::EPS_WIDTH-1:0] hit_eps;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NA; a++) begin
        box_min[a] <= CW'(rbs_pkg::BOX_MIN_RESET);
        box_max[a] <= CW'(rbs_pkg::BOX_MAX_RESET);
      end
      hit_eps <= rbs_pkg::HIT_EPS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        rbs_pkg::REG_BOX_MIN_X: box_min[0] <= cfg.data[CW-1:0];
        rbs_pkg::REG_BOX_MIN_Y: box_min[1] <= cfg.data[CW-1:0];
        rbs_pkg::REG_BOX_MIN_Z: box_min[2] <= cfg.data[CW-1:0];
        rbs_pkg::REG_BOX_MAX_X: box_max[0] <= cfg.data[CW-1:0];
        rbs_pkg::REG_BOX_MAX_Y: box_max[1] <= cfg.data[CW-1:0];
        rbs_pkg::REG_BOX_MAX_Z: box_max[2] <= cfg.data[CW-1:0];
        rbs_pkg::REG_HIT_EPS:   hit_eps    <= cfg.data[rbs_pkg::EPS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld;

  assign en            = ~hit_out.valid | hit_out.ready;
  assign ray_in.ready  = en;
  assign hit_out.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], ray_in.valid};
    end
  end

  logic signed [CW-1:0] org [NA];
  logic signed [CW-1:0] dir [NA];
  logic signed [CW-1:0] tn [NA];
  logic signed [CW-1:0] tx [NA];
  logic [NA-1:0] miss;

  assign org[0] = ray_in.origin_x;
  assign org[1] = ray_in.origin_y;
  assign org[2] = ray_in.origin_z;
  assign dir[0] = ray_in.dir_x;
  assign dir[1] = ray_in.dir_y;
  assign dir[2] = ray_in.dir_z;

  for (genvar a = 0; a < NA; a++) begin : g_lane
    rbs_slab_lane #(.COORD_WIDTH(CW)) u_lane (
      .clk(clk), .en(en), .org(org[a]), .dir(dir[a]),
      .lo(box_min[a]), .hi(box_max[a]),
      .tn(tn[a]), .tx(tx[a]), .miss(miss[a])
    );
  end

  rbs_merge #(.COORD_WIDTH(CW)) u_merge (
    .clk(clk), .en(en), .tn(tn), .tx(tx), .miss(miss),
    .eps(hit_eps), .is_hit(hit_out.is_hit)
  );

  a_ready_tracks_stall: assert property (@(posedge clk) disable iff (rst)
    ray_in.ready == (hit_out.ready || !hit_out.valid))
    else $error("ray_in.ready does not follow output stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (ray_in.valid && ray_in.ready) |=> vld[0])
    else $error("accepted ray not tracked in valid chain");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (hit_out.valid && !hit_out.ready) |=> (hit_out.valid && $stable(hit_out.is_hit)))
    else $error("stalled result changed");

  a_eps_write: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.index == rbs_pkg::REG_HIT_EPS) |=>
      hit_eps == $past(cfg.data[rbs_pkg::EPS_WIDTH-1:0]))
    else $error("hit_epsilon write lost");
endmodule
`default_nettype wire
